// ===== rtl/spc_pkg.sv =====
// Shared constants for the playback session controller: sizes, opcodes,
// phase codes and outcome codes.
// No dependencies.
`default_nettype none

package spc_pkg;

    localparam int FIFO_DEPTH = 16;
    localparam int HIST_DEPTH = 8;
    localparam int TAG_BITS   = 32;

    localparam int FA_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FC_W = $clog2(FIFO_DEPTH + 1);
    localparam int HA_W = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int HC_W = $clog2(HIST_DEPTH + 1);
    localparam int FH_W = TAG_BITS + 16;

    localparam logic [3:0] OP_START    = 4'd0;
    localparam logic [3:0] OP_ENQUEUE  = 4'd1;
    localparam logic [3:0] OP_PUMP     = 4'd2;
    localparam logic [3:0] OP_MARK     = 4'd3;
    localparam logic [3:0] OP_DRAIN    = 4'd4;
    localparam logic [3:0] OP_COMPLETE = 4'd5;
    localparam logic [3:0] OP_FAIL     = 4'd6;
    localparam logic [3:0] OP_ABORT    = 4'd7;
    localparam logic [3:0] OP_QUERY    = 4'd8;

    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_PREP  = 2'd1;
    localparam logic [1:0] PH_PLAY  = 2'd2;
    localparam logic [1:0] PH_DRAIN = 2'd3;

    localparam logic [3:0] OC_NONE     = 4'd0;
    localparam logic [3:0] OC_OK       = 4'd1;
    localparam logic [3:0] OC_REPLAY   = 4'd2;
    localparam logic [3:0] OC_STALE    = 4'd3;
    localparam logic [3:0] OC_CONT_PREP = 4'd4;
    localparam logic [3:0] OC_RESEND   = 4'd5;
    localparam logic [3:0] OC_CONT_DRN = 4'd6;
    localparam logic [3:0] OC_PREPARE  = 4'd7;
    localparam logic [3:0] OC_ACCEPTED = 4'd8;
    localparam logic [3:0] OC_IGNORED  = 4'd9;
    localparam logic [3:0] OC_OVERFLOW = 4'd10;
    localparam logic [3:0] OC_PACKET   = 4'd11;

    localparam logic [7:0] FINAL_CODE_ERROR = 8'd255;
    localparam logic [4:0] PREROLL_RESET    = 5'd4;

endpackage

`default_nettype wire

// ===== rtl/spc_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module spc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic                                     i_re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/playback_session_controller.sv =====
// Playback session controller: session phases, packet FIFO and history
// tables, sequenced over three instances of spc_ram. Uses spc_pkg.
//
// Usage:
//  - Input channel i_in_valid / o_in_ready carries one event beat (opcode
//    plus its fields). Output channel o_out_valid / i_out_ready carries
//    result beats; o_last marks the final beat of an event.
//  - Config: i_cfg_we writes the 5-bit preroll threshold (reset 4). Write
//    only while no event is in flight.
//  - One event is worked at a time; o_in_ready is high only while the
//    sequencer is idle. A finished result may still wait in the output
//    register while the next event is taken.
//  - Simple events are settled in the execute state, which registers their
//    result. start and query walk the history memories newest first, one
//    entry a cycle through the registered read port while the receiver
//    takes results: start walks the final table then the stale table, query
//    the final table only. pump streams one packet beat a cycle out of the
//    FIFO memory while the receiver takes beats.
//  - A stalled receiver holds the sequencer in place; nothing is dropped.
//  - Reset (synchronous, active low) clears phase, generation, tags,
//    counters and the output valid; memories need no clearing because
//    fill counts bound every read.
`default_nettype none

module playback_session_controller
    import spc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_sentence_tag,
    input  wire logic        i_has_return_state,
    input  wire logic [1:0]  i_return_state_in,
    input  wire logic [31:0] i_generation_in,
    input  wire logic        i_packet_present,
    input  wire logic [31:0] i_packet_word,
    input  wire logic [4:0]  i_sink_credit,
    input  wire logic [7:0]  i_completion_code_in,
    input  wire logic [7:0]  i_reason_code_in,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [3:0]       o_outcome,
    output logic [31:0]      o_generation_out,
    output logic [31:0]      o_superseded_tag,
    output logic [7:0]       o_final_code_out,
    output logic [7:0]       o_final_reason_out,
    output logic [1:0]       o_return_state_out,
    output logic [31:0]      o_packet_out,
    output logic [1:0]       o_phase_out,
    output logic [4:0]       o_buffered_count,
    output logic             o_last
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_SRCH = 2'd2;
    localparam logic [1:0] ST_PUMP = 2'd3;

    // control state
    logic [1:0]          r_state, n_state;
    logic [4:0]          r_thr;
    logic [1:0]          r_phase, n_phase;
    logic [31:0]         r_gen, n_gen;
    logic [TAG_BITS-1:0] r_cur_tag, n_cur_tag;
    logic [1:0]          r_rs, n_rs;
    logic                r_pre, n_pre;
    logic [FA_W-1:0]     r_head, n_head;
    logic [FC_W-1:0]     r_cnt, n_cnt;
    logic [HA_W-1:0]     r_fwp, n_fwp, r_swp, n_swp;
    logic [HC_W-1:0]     r_fcnt, n_fcnt, r_scnt, n_scnt;
    logic [HC_W-1:0]     r_ri, n_ri;
    logic                r_rqv, n_rqv;
    logic                r_stale, n_stale;
    logic [FC_W-1:0]     r_rem, n_rem;
    logic                r_ov;

    // latched event
    logic [3:0]          r_op;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_has_rs;
    logic [1:0]          r_rs_in;
    logic [31:0]         r_gen_in;
    logic                r_pkt_present;
    logic [31:0]         r_pkt;
    logic [4:0]          r_credit;
    logic [7:0]          r_code;
    logic [7:0]          r_reason;

    // result staging
    logic                emit, e_last;
    logic [3:0]          e_outcome;
    logic [TAG_BITS-1:0] e_sup;
    logic [7:0]          e_fc, e_fr;
    logic [1:0]          e_rs;
    logic [31:0]         e_pkt;

    // memory ports
    logic                f_we, f_re;
    logic [FA_W-1:0]     f_waddr, f_raddr;
    logic [31:0]         f_rdata;
    logic                fh_we, sh_we, h_re;
    logic [HA_W-1:0]     h_raddr;
    logic [FH_W-1:0]     fh_wdata, fh_rdata;
    logic [TAG_BITS-1:0] sh_wdata, sh_rdata;

    logic                out_free, in_acc;
    logic [FA_W-1:0]     head_inc;
    logic [FC_W:0]       wsum;
    logic [HA_W-1:0]     srch_wp;
    logic [HC_W-1:0]     srch_cnt;
    logic [HC_W:0]       s_wpx, s_off, s_addr;
    logic                issue, hit, gen_ok, pump_open;
    logic [TAG_BITS-1:0] h_tag;
    logic [7:0]          h_code, h_reason;
    logic [FC_W-1:0]     pump_n;

    assign out_free   = !r_ov || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    assign head_inc = (r_head == FA_W'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
    assign wsum     = (FC_W + 1)'(r_head) + (FC_W + 1)'(r_cnt);
    assign f_waddr  = (wsum >= (FC_W + 1)'(FIFO_DEPTH))
                    ? FA_W'(wsum - (FC_W + 1)'(FIFO_DEPTH)) : FA_W'(wsum);
    assign f_raddr  = (r_state == ST_EXEC) ? r_head : head_inc;

    // i-th newest history entry sits at (wp - 1 - i) mod depth
    assign srch_wp  = r_stale ? r_swp : r_fwp;
    assign srch_cnt = r_stale ? r_scnt : r_fcnt;
    assign s_wpx    = (HC_W + 1)'(srch_wp);
    assign s_off    = (HC_W + 1)'(r_ri) + 1'b1;
    assign s_addr   = (s_wpx >= s_off) ? s_wpx - s_off
                    : s_wpx + (HC_W + 1)'(HIST_DEPTH) - s_off;
    assign h_raddr  = HA_W'(s_addr);
    assign issue    = (r_ri < srch_cnt);

    assign h_tag    = fh_rdata[FH_W-1:16];
    assign h_code   = fh_rdata[15:8];
    assign h_reason = fh_rdata[7:0];
    assign hit      = r_rqv && (r_stale ? (sh_rdata == r_tag) : (h_tag == r_tag));

    assign gen_ok    = (r_gen_in == r_gen);
    assign pump_open = (r_phase == PH_DRAIN) || ((r_phase == PH_PLAY) && r_pre);
    assign pump_n    = (32'(r_credit) < 32'(r_cnt)) ? FC_W'(r_credit) : r_cnt;

    assign fh_wdata = {r_cur_tag, ((r_op == OP_COMPLETE) ? r_code : FINAL_CODE_ERROR),
                       r_reason};
    assign sh_wdata = r_cur_tag;

    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_gen     = r_gen;
        n_cur_tag = r_cur_tag;
        n_rs      = r_rs;
        n_pre     = r_pre;
        n_head    = r_head;
        n_cnt     = r_cnt;
        n_fwp     = r_fwp;
        n_fcnt    = r_fcnt;
        n_swp     = r_swp;
        n_scnt    = r_scnt;
        n_ri      = r_ri;
        n_rqv     = r_rqv;
        n_stale   = r_stale;
        n_rem     = r_rem;
        emit      = 1'b0;
        e_last    = 1'b1;
        e_outcome = OC_NONE;
        e_sup     = '0;
        e_fc      = '0;
        e_fr      = '0;
        e_rs      = '0;
        e_pkt     = '0;
        f_we      = 1'b0;
        f_re      = 1'b0;
        fh_we     = 1'b0;
        sh_we     = 1'b0;
        h_re      = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                    case (r_op)
                        OP_START, OP_QUERY: begin
                            if (r_op == OP_START && r_tag == '0) begin
                                emit = 1'b1;
                            end else begin
                                n_ri    = '0;
                                n_rqv   = 1'b0;
                                n_stale = 1'b0;
                                n_state = ST_SRCH;
                            end
                        end
                        OP_ENQUEUE: begin
                            emit = 1'b1;
                            if (!r_pkt_present || !(r_phase == PH_PREP || r_phase == PH_PLAY)) begin
                                e_outcome = OC_IGNORED;
                            end else if (r_cnt == FC_W'(FIFO_DEPTH)) begin
                                e_outcome = OC_OVERFLOW;
                            end else begin
                                f_we  = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                if (32'(n_cnt) >= 32'(r_thr)) begin
                                    n_pre = 1'b1;
                                end
                                e_outcome = OC_ACCEPTED;
                            end
                        end
                        OP_PUMP: begin
                            if (pump_open && r_cnt != '0 && r_credit != '0) begin
                                f_re    = 1'b1;
                                n_rem   = pump_n;
                                n_state = ST_PUMP;
                            end else begin
                                emit = 1'b1;
                            end
                        end
                        OP_MARK: begin
                            emit = 1'b1;
                            if (gen_ok && r_phase == PH_PREP) begin
                                n_phase = PH_PLAY;
                                if (32'(r_cnt) >= 32'(r_thr)) begin
                                    n_pre = 1'b1;
                                end
                                e_outcome = OC_OK;
                            end
                        end
                        OP_DRAIN: begin
                            emit = 1'b1;
                            if (gen_ok && r_tag == r_cur_tag && r_phase == PH_PLAY) begin
                                n_phase   = PH_DRAIN;
                                n_pre     = 1'b1;
                                e_outcome = OC_OK;
                            end
                        end
                        OP_COMPLETE, OP_FAIL: begin
                            emit = 1'b1;
                            if (gen_ok && ((r_op == OP_COMPLETE) ? (r_phase == PH_DRAIN)
                                                                 : (r_phase != PH_IDLE))) begin
                                fh_we  = 1'b1;
                                n_fwp  = (r_fwp == HA_W'(HIST_DEPTH - 1)) ? '0 : r_fwp + 1'b1;
                                n_fcnt = (r_fcnt == HC_W'(HIST_DEPTH)) ? r_fcnt : r_fcnt + 1'b1;
                                n_cur_tag = '0;
                                n_head    = '0;
                                n_cnt     = '0;
                                n_phase   = PH_IDLE;
                                n_pre     = 1'b0;
                                e_rs      = r_rs;
                                e_outcome = OC_OK;
                            end
                        end
                        OP_ABORT: begin
                            emit = 1'b1;
                            if (r_cur_tag != '0) begin
                                sh_we  = 1'b1;
                                n_swp  = (r_swp == HA_W'(HIST_DEPTH - 1)) ? '0 : r_swp + 1'b1;
                                n_scnt = (r_scnt == HC_W'(HIST_DEPTH)) ? r_scnt : r_scnt + 1'b1;
                            end
                            n_cur_tag = '0;
                            n_head    = '0;
                            n_cnt     = '0;
                            n_phase   = PH_IDLE;
                            n_pre     = 1'b0;
                            n_rs      = '0;
                            n_gen     = r_gen + 1'b1;
                            e_outcome = OC_OK;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            ST_SRCH: begin
                if (out_free) begin
                    if (hit && !r_stale) begin
                        if (r_op == OP_QUERY) begin
                            emit      = 1'b1;
                            e_outcome = OC_OK;
                            e_fc      = h_code;
                            e_fr      = h_reason;
                            n_state   = ST_IDLE;
                        end else if (h_code != '0) begin
                            emit      = 1'b1;
                            e_outcome = OC_REPLAY;
                            e_fc      = h_code;
                            e_fr      = h_reason;
                            n_state   = ST_IDLE;
                        end else begin
                            n_ri    = '0;
                            n_rqv   = 1'b0;
                            n_stale = 1'b1;
                        end
                    end else if (hit) begin
                        emit      = 1'b1;
                        e_outcome = OC_STALE;
                        n_state   = ST_IDLE;
                    end else if (!issue && !r_rqv) begin
                        if (r_op == OP_QUERY) begin
                            emit    = 1'b1;
                            n_state = ST_IDLE;
                        end else if (!r_stale) begin
                            n_ri    = '0;
                            n_stale = 1'b1;
                        end else begin
                            emit    = 1'b1;
                            n_state = ST_IDLE;
                            if (r_tag == r_cur_tag) begin
                                case (r_phase)
                                    PH_PREP:  e_outcome = OC_CONT_PREP;
                                    PH_PLAY:  e_outcome = OC_RESEND;
                                    PH_DRAIN: e_outcome = OC_CONT_DRN;
                                    default:  e_outcome = OC_NONE;
                                endcase
                            end else begin
                                // supersede the active sentence, if any
                                if (r_phase != PH_IDLE) begin
                                    e_sup = r_cur_tag;
                                    if (r_cur_tag != '0) begin
                                        sh_we  = 1'b1;
                                        n_swp  = (r_swp == HA_W'(HIST_DEPTH - 1))
                                               ? '0 : r_swp + 1'b1;
                                        n_scnt = (r_scnt == HC_W'(HIST_DEPTH))
                                               ? r_scnt : r_scnt + 1'b1;
                                    end
                                end
                                if (r_has_rs) begin
                                    n_rs = r_rs_in;
                                end else if (r_phase == PH_IDLE) begin
                                    n_rs = '0;
                                end
                                n_head    = '0;
                                n_cnt     = '0;
                                n_cur_tag = r_tag;
                                n_pre     = 1'b0;
                                n_phase   = PH_PREP;
                                n_gen     = r_gen + 1'b1;
                                e_outcome = OC_PREPARE;
                            end
                        end
                    end else begin
                        h_re  = issue;
                        n_ri  = issue ? r_ri + 1'b1 : r_ri;
                        n_rqv = issue;
                    end
                end
            end
            ST_PUMP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    e_outcome = OC_PACKET;
                    e_pkt     = f_rdata;
                    e_last    = (r_rem == FC_W'(1));
                    n_head    = head_inc;
                    n_cnt     = r_cnt - 1'b1;
                    n_rem     = r_rem - 1'b1;
                    if (r_rem == FC_W'(1)) begin
                        n_state = ST_IDLE;
                    end else begin
                        f_re = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_thr     <= PREROLL_RESET;
            r_phase   <= PH_IDLE;
            r_gen     <= '0;
            r_cur_tag <= '0;
            r_rs      <= '0;
            r_pre     <= 1'b0;
            r_head    <= '0;
            r_cnt     <= '0;
            r_fwp     <= '0;
            r_fcnt    <= '0;
            r_swp     <= '0;
            r_scnt    <= '0;
            r_ri      <= '0;
            r_rqv     <= 1'b0;
            r_stale   <= 1'b0;
            r_rem     <= '0;
            r_ov      <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_gen     <= n_gen;
            r_cur_tag <= n_cur_tag;
            r_rs      <= n_rs;
            r_pre     <= n_pre;
            r_head    <= n_head;
            r_cnt     <= n_cnt;
            r_fwp     <= n_fwp;
            r_fcnt    <= n_fcnt;
            r_swp     <= n_swp;
            r_scnt    <= n_scnt;
            r_ri      <= n_ri;
            r_rqv     <= n_rqv;
            r_stale   <= n_stale;
            r_rem     <= n_rem;
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            if (emit) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload registers: event latch and result beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op          <= i_opcode;
            r_tag         <= TAG_BITS'(i_sentence_tag);
            r_has_rs      <= i_has_return_state;
            r_rs_in       <= i_return_state_in;
            r_gen_in      <= i_generation_in;
            r_pkt_present <= i_packet_present;
            r_pkt         <= i_packet_word;
            r_credit      <= i_sink_credit;
            r_code        <= i_completion_code_in;
            r_reason      <= i_reason_code_in;
        end
        if (emit) begin
            o_outcome          <= e_outcome;
            o_generation_out   <= n_gen;
            o_superseded_tag   <= 32'(e_sup);
            o_final_code_out   <= e_fc;
            o_final_reason_out <= e_fr;
            o_return_state_out <= e_rs;
            o_packet_out       <= e_pkt;
            o_phase_out        <= n_phase;
            o_buffered_count   <= 5'(n_cnt);
            o_last             <= e_last;
        end
    end

    assign o_out_valid = r_ov;

    spc_ram #(.WIDTH(32), .DEPTH(FIFO_DEPTH)) u_fifo_ram (
        .i_clk   (i_clk),
        .i_we    (f_we),
        .i_waddr (f_waddr),
        .i_wdata (r_pkt),
        .i_re    (f_re),
        .i_raddr (f_raddr),
        .o_rdata (f_rdata)
    );

    spc_ram #(.WIDTH(FH_W), .DEPTH(HIST_DEPTH)) u_final_ram (
        .i_clk   (i_clk),
        .i_we    (fh_we),
        .i_waddr (r_fwp),
        .i_wdata (fh_wdata),
        .i_re    (h_re && !r_stale),
        .i_raddr (h_raddr),
        .o_rdata (fh_rdata)
    );

    spc_ram #(.WIDTH(TAG_BITS), .DEPTH(HIST_DEPTH)) u_stale_ram (
        .i_clk   (i_clk),
        .i_we    (sh_we),
        .i_waddr (r_swp),
        .i_wdata (sh_wdata),
        .i_re    (h_re && r_stale),
        .i_raddr (h_raddr),
        .o_rdata (sh_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/spc_checker.sv =====
// Port-level checks for the playback session controller, bound to the top.
// Uses spc_pkg.
`default_nettype none

module spc_checker
    import spc_pkg::*;
(
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        o_in_ready,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic [3:0]  o_outcome,
    input wire logic [1:0]  o_phase_out,
    input wire logic [4:0]  o_buffered_count
);

    // results are gone after reset
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat valid after reset");

    // one event at a time
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("event accepted while another is in flight");

    // stalled beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result beat dropped under stall");

    // packets only leave while playing or draining
    a_pkt_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome == OC_PACKET) |->
        (o_phase_out == PH_PLAY || o_phase_out == PH_DRAIN))
        else $error("packet beat outside playing or draining");

    // a fresh session starts empty and preparing
    a_prepare: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_outcome == OC_PREPARE) |->
        (o_phase_out == PH_PREP && o_buffered_count == 5'd0))
        else $error("new session not empty or not preparing");

endmodule

bind playback_session_controller spc_checker u_spc_checker (.*);

`default_nettype wire

// ===== dv/spc_checker.sv =====
// Result scoreboard for the playback session controller: watches the event
// and result channels, predicts each event's result beats and compares them.
// Depends on spc_pkg.
`timescale 1ns / 1ps

module spc_scoreboard
    import spc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_ready,
    input  wire logic [3:0]  i_opcode,
    input  wire logic [31:0] i_sentence_tag,
    input  wire logic        i_has_return_state,
    input  wire logic [1:0]  i_return_state_in,
    input  wire logic [31:0] i_generation_in,
    input  wire logic        i_packet_present,
    input  wire logic [31:0] i_packet_word,
    input  wire logic [4:0]  i_sink_credit,
    input  wire logic [7:0]  i_completion_code_in,
    input  wire logic [7:0]  i_reason_code_in,
    input  wire logic        i_cfg_we,
    input  wire logic [4:0]  i_cfg_wdata,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_ready,
    input  wire logic [3:0]  i_outcome,
    input  wire logic [31:0] i_generation_out,
    input  wire logic [31:0] i_superseded_tag,
    input  wire logic [7:0]  i_final_code_out,
    input  wire logic [7:0]  i_final_reason_out,
    input  wire logic [1:0]  i_return_state_out,
    input  wire logic [31:0] i_packet_out,
    input  wire logic [1:0]  i_phase_out,
    input  wire logic [4:0]  i_buffered_count,
    input  wire logic        i_last,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_beats_seen
);

    typedef struct packed {
        logic [3:0]  outcome;
        logic [31:0] generation;
        logic [31:0] superseded;
        logic [7:0]  final_code;
        logic [7:0]  final_reason;
        logic [1:0]  ret_st;
        logic [31:0] packet;
        logic [1:0]  phase;
        logic [4:0]  count;
        logic        last;
    } t_session_beat;

    typedef struct packed {
        logic [31:0] tag;
        logic [7:0]  code;
        logic [7:0]  reason;
    } t_final_rec;

    localparam int RING_SIZE = 1024;

    t_session_beat exp_ring [RING_SIZE];
    int            exp_wr, exp_rd;

    logic [4:0]  threshold;
    logic [1:0]  phase;
    logic [31:0] generation;
    logic [31:0] cur_tag;
    logic [1:0]  ret_state;
    logic        preroll_ok;
    logic [31:0] pkt_fifo [FIFO_DEPTH];
    int          head, count;
    t_final_rec  finals [HIST_DEPTH];
    int          final_cnt;
    logic [31:0] stales [HIST_DEPTH];
    int          stale_cnt;

    function automatic t_session_beat make_beat(logic [3:0] oc, logic [31:0] sup,
            logic [7:0] fc, logic [7:0] fr, logic [1:0] rs, logic [31:0] pkt);
        t_session_beat b;
        b = '{outcome: oc, generation: generation, superseded: sup, final_code: fc,
              final_reason: fr, ret_st: rs, packet: pkt, phase: phase,
              count: count[4:0], last: 1'b0};
        return b;
    endfunction

    function automatic void add_beat(t_session_beat b);
        exp_ring[exp_wr % RING_SIZE] = b;
        exp_wr++;
    endfunction

    function automatic int find_final(logic [31:0] tag);
        for (int i = 0; i < final_cnt; i++)
            if (finals[i].tag == tag) return i;
        return -1;
    endfunction

    function automatic bit is_stale(logic [31:0] tag);
        for (int i = 0; i < stale_cnt; i++)
            if (stales[i] == tag) return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_stale(logic [31:0] tag);
        if (tag == 0) return;
        for (int i = HIST_DEPTH - 1; i > 0; i--) stales[i] = stales[i-1];
        stales[0] = tag;
        if (stale_cnt < HIST_DEPTH) stale_cnt++;
    endfunction

    function automatic void push_final(logic [31:0] tag, logic [7:0] c, logic [7:0] r);
        for (int i = HIST_DEPTH - 1; i > 0; i--) finals[i] = finals[i-1];
        finals[0] = '{tag: tag, code: c, reason: r};
        if (final_cnt < HIST_DEPTH) final_cnt++;
    endfunction

    function automatic void close_session();
        cur_tag = 0; head = 0; count = 0; phase = PH_IDLE; preroll_ok = 1'b0;
    endfunction

    // Advance the session model by one event and queue its result beats.
    function automatic void predict_event();
        int f;
        int moved;
        bit sup_on;
        logic [31:0] sup;
        logic [3:0] oc;
        logic [1:0] rs;
        bit allowed;
        logic [31:0] tag;
        logic [31:0] p;
        tag = i_sentence_tag;
        case (i_opcode)
            OP_START: begin
                f = find_final(tag);
                if (tag == 0) add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
                else if (f >= 0 && finals[f].code != 0)
                    add_beat(make_beat(OC_REPLAY, 0, finals[f].code,
                                       finals[f].reason, 0, 0));
                else if (is_stale(tag)) add_beat(make_beat(OC_STALE, 0, 0, 0, 0, 0));
                else if (tag == cur_tag) begin
                    oc = (phase == PH_PREP) ? OC_CONT_PREP :
                         (phase == PH_PLAY) ? OC_RESEND :
                         (phase == PH_DRAIN) ? OC_CONT_DRN : OC_NONE;
                    add_beat(make_beat(oc, 0, 0, 0, 0, 0));
                end else begin
                    sup_on = phase != PH_IDLE;
                    sup = 0;
                    if (sup_on) begin
                        sup = cur_tag;
                        push_stale(cur_tag);
                    end
                    head = 0; count = 0; cur_tag = tag; preroll_ok = 1'b0;
                    if (i_has_return_state) ret_state = i_return_state_in;
                    else if (!sup_on) ret_state = PH_IDLE;
                    phase = PH_PREP;
                    generation++;
                    add_beat(make_beat(OC_PREPARE, sup, 0, 0, 0, 0));
                end
            end
            OP_ENQUEUE: begin
                if (!i_packet_present || (phase != PH_PREP && phase != PH_PLAY))
                    add_beat(make_beat(OC_IGNORED, 0, 0, 0, 0, 0));
                else if (count >= FIFO_DEPTH)
                    add_beat(make_beat(OC_OVERFLOW, 0, 0, 0, 0, 0));
                else begin
                    pkt_fifo[FA_W'((head + count) % FIFO_DEPTH)] = i_packet_word;
                    count++;
                    if (count >= threshold) preroll_ok = 1'b1;
                    add_beat(make_beat(OC_ACCEPTED, 0, 0, 0, 0, 0));
                end
            end
            OP_PUMP: begin
                moved = 0;
                if (phase == PH_DRAIN || (phase == PH_PLAY && preroll_ok)) begin
                    while (count > 0 && moved < i_sink_credit) begin
                        p = pkt_fifo[FA_W'(head)];
                        head = (head + 1) % FIFO_DEPTH;
                        count--;
                        add_beat(make_beat(OC_PACKET, 0, 0, 0, 0, p));
                        moved++;
                    end
                end
                if (moved == 0) add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
            end
            OP_MARK: begin
                if (i_generation_in != generation || phase != PH_PREP)
                    add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
                else begin
                    phase = PH_PLAY;
                    if (count >= threshold) preroll_ok = 1'b1;
                    add_beat(make_beat(OC_OK, 0, 0, 0, 0, 0));
                end
            end
            OP_DRAIN: begin
                if (i_generation_in != generation || tag != cur_tag || phase != PH_PLAY)
                    add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
                else begin
                    phase = PH_DRAIN;
                    preroll_ok = 1'b1;
                    add_beat(make_beat(OC_OK, 0, 0, 0, 0, 0));
                end
            end
            OP_COMPLETE, OP_FAIL: begin
                allowed = (i_opcode == OP_COMPLETE) ? (phase == PH_DRAIN) : (phase != PH_IDLE);
                if (i_generation_in != generation || !allowed)
                    add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
                else begin
                    rs = ret_state;
                    push_final(cur_tag, (i_opcode == OP_COMPLETE) ? i_completion_code_in
                               : FINAL_CODE_ERROR, i_reason_code_in);
                    close_session();
                    add_beat(make_beat(OC_OK, 0, 0, 0, rs, 0));
                end
            end
            OP_ABORT: begin
                if (cur_tag != 0) push_stale(cur_tag);
                close_session();
                ret_state = PH_IDLE;
                generation++;
                add_beat(make_beat(OC_OK, 0, 0, 0, 0, 0));
            end
            OP_QUERY: begin
                f = find_final(tag);
                if (f >= 0)
                    add_beat(make_beat(OC_OK, 0, finals[f].code, finals[f].reason, 0, 0));
                else add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
            end
            default: add_beat(make_beat(OC_NONE, 0, 0, 0, 0, 0));
        endcase
        exp_ring[(exp_wr - 1) % RING_SIZE].last = 1'b1;
    endfunction

    always @(posedge i_clk) begin
        t_session_beat got, want;
        if (!i_rst_n) begin
            threshold = PREROLL_RESET;
            phase = PH_IDLE; generation = 0; cur_tag = 0; ret_state = PH_IDLE;
            preroll_ok = 1'b0; head = 0; count = 0; final_cnt = 0; stale_cnt = 0;
            exp_wr = 0;
            exp_rd = 0;
            o_fail_count = 0;
            o_beats_seen = 0;
        end else begin
            if (i_cfg_we) threshold = i_cfg_wdata;
            // Check the result beat before the new event so its prediction
            // never races the one already on the output.
            if (i_out_valid && i_out_ready) begin
                got = '{i_outcome, i_generation_out, i_superseded_tag, i_final_code_out,
                        i_final_reason_out, i_return_state_out, i_packet_out, i_phase_out,
                        i_buffered_count, i_last};
                o_beats_seen++;
                if (exp_wr == exp_rd) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = exp_ring[exp_rd % RING_SIZE];
                    exp_rd++;
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("beat mismatch\n  expected %p\n  actual   %p", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) predict_event();
        end
        o_pending = exp_wr - exp_rd;
    end

endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the playback session controller: clock, reset, event
// stimulus, receiver stalls and verdict. Depends on spc_pkg, spc_scoreboard and the DUT.
`timescale 1ns / 1ps

module tb_top
    import spc_pkg::*;
();

    localparam int RANDOM_EVENTS = 440;
    localparam int CYCLE_LIMIT   = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [3:0]  opcode = '0;
    logic [31:0] sentence_tag = '0;
    logic        has_rs = 1'b0;
    logic [1:0]  rs_in = '0;
    logic [31:0] gen_in = '0;
    logic        pkt_present = 1'b0;
    logic [31:0] pkt_word = '0;
    logic [4:0]  credit = '0;
    logic [7:0]  code_in = '0;
    logic [7:0]  reason_in = '0;
    logic        cfg_we = 1'b0;
    logic [4:0]  cfg_wdata = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  outcome;
    logic [31:0] generation_out, superseded_tag, packet_out;
    logic [7:0]  final_code, final_reason;
    logic [1:0]  return_state_out, phase_out;
    logic [4:0]  buffered;
    logic        last;

    int fail_count, pending, beats_seen;
    int cycle_count = 0;
    bit long_hold = 1'b0;
    int sent = 0;
    int base_sent;

    // Session bookkeeping the stimulus uses to build well-formed sequences.
    logic [31:0] live_tag = '0;
    logic [31:0] known_gen = '0;
    logic [31:0] recent_tags [8];
    logic [4:0]  th_list [6] = '{5'd0, 5'd1, 5'd16, 5'd31, 5'd4, 5'd7};

    always #2 i_clk = ~i_clk;

    playback_session_controller dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_opcode(opcode), .i_sentence_tag(sentence_tag),
        .i_has_return_state(has_rs), .i_return_state_in(rs_in),
        .i_generation_in(gen_in), .i_packet_present(pkt_present),
        .i_packet_word(pkt_word), .i_sink_credit(credit),
        .i_completion_code_in(code_in), .i_reason_code_in(reason_in),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_outcome(outcome), .o_generation_out(generation_out),
        .o_superseded_tag(superseded_tag), .o_final_code_out(final_code),
        .o_final_reason_out(final_reason), .o_return_state_out(return_state_out),
        .o_packet_out(packet_out), .o_phase_out(phase_out),
        .o_buffered_count(buffered), .o_last(last)
    );

    spc_scoreboard u_scoreboard (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_opcode(opcode), .i_sentence_tag(sentence_tag),
        .i_has_return_state(has_rs), .i_return_state_in(rs_in),
        .i_generation_in(gen_in), .i_packet_present(pkt_present),
        .i_packet_word(pkt_word), .i_sink_credit(credit),
        .i_completion_code_in(code_in), .i_reason_code_in(reason_in),
        .i_cfg_we(cfg_we), .i_cfg_wdata(cfg_wdata),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_outcome(outcome), .i_generation_out(generation_out),
        .i_superseded_tag(superseded_tag), .i_final_code_out(final_code),
        .i_final_reason_out(final_reason), .i_return_state_out(return_state_out),
        .i_packet_out(packet_out), .i_phase_out(phase_out),
        .i_buffered_count(buffered), .i_last(last),
        .o_fail_count(fail_count), .o_pending(pending), .o_beats_seen(beats_seen)
    );

    // Watchdog: end the run if the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Receiver: a random stall per beat, with one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (long_hold) begin
                out_ready <= 1'b0;
                repeat (120) @(posedge i_clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            out_ready <= 1'b1;
            @(posedge i_clk iff out_valid);
        end
    end

    // Offer one event beat after a random gap and hold it until accepted.
    // Valid stays high after the accept; idle_input or a gap in the next call drops it.
    task automatic send_event(logic [3:0] op, logic [31:0] tag, logic hrs, logic [1:0] rs,
            logic [31:0] gen, logic pp, logic [31:0] pw, logic [4:0] cr,
            logic [7:0] cc, logic [7:0] rc, bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        opcode <= op; sentence_tag <= tag; has_rs <= hrs; rs_in <= rs;
        gen_in <= gen; pkt_present <= pp; pkt_word <= pw; credit <= cr;
        code_in <= cc; reason_in <= rc;
        @(posedge i_clk iff in_ready);
        sent++;
    endtask

    // Drop valid after the last accepted beat.
    task automatic idle_input();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write the preroll threshold once every pending beat has drained.
    task automatic set_threshold(logic [4:0] value);
        in_valid <= 1'b0;
        @(posedge i_clk iff (pending == 0));
        repeat (40) @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_word();
        return $urandom;
    endfunction

    // Pick a tag: mostly fresh, sometimes a recent or the live one, to hit
    // replay, stale and resend paths.
    function automatic logic [31:0] pick_tag();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return recent_tags[$urandom_range(0, 7)];
        if (r == 2) return live_tag;
        if (r == 3) return 32'hFFFF_FFFF;
        return rand_word() | 32'h1;
    endfunction

    task automatic remember_tag(logic [31:0] tag);
        for (int i = 7; i > 0; i--) recent_tags[i] = recent_tags[i-1];
        recent_tags[0] = tag;
    endtask

    // Drive one whole session: start, fill, play, pump, drain, finish, sometimes query.
    task automatic run_session();
        logic [31:0] tag;
        tag = pick_tag();
        remember_tag(tag);
        send_event(OP_START, tag, 1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                   0, 0, 0, 0, 0, 0);
        idle_input();
        @(posedge i_clk iff pending == 0);
        known_gen = generation_out;
        live_tag = tag;
        repeat ($urandom_range(0, 6))
            send_event(OP_ENQUEUE, tag, 0, 0, 0, $urandom_range(0, 7) != 0, rand_word(),
                       0, 0, 0);
        send_event(OP_MARK, tag, 0, 0, ($urandom_range(0, 7) == 0) ? rand_word() : known_gen,
                   0, 0, 0, 0, 0);
        repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 1) != 0)
                send_event(OP_ENQUEUE, tag, 0, 0, 0, 1, rand_word(), 0, 0, 0);
            else
                send_event(OP_PUMP, tag, 0, 0, 0, 0, 0, 5'($urandom_range(0, 16)), 0, 0);
        end
        if ($urandom_range(0, 9) == 0) begin
            send_event(OP_START, pick_tag(), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)), 0, 0, 0, 0, 0, 0);
        end
        send_event(OP_DRAIN, ($urandom_range(0, 9) == 0) ? rand_word() : tag, 0, 0,
                   known_gen, 0, 0, 0, 0, 0);
        send_event(OP_PUMP, tag, 0, 0, 0, 0, 0, 5'($urandom_range(0, 16)), 0, 0);
        case ($urandom_range(0, 5))
            0: send_event(OP_FAIL, tag, 0, 0, known_gen, 0, 0, 0, 0,
                          8'($urandom_range(0, 255)));
            1: send_event(OP_ABORT, tag, 0, 0, 0, 0, 0, 0, 0, 0);
            default: send_event(OP_COMPLETE, tag, 0, 0, known_gen, 0, 0, 0,
                                8'($urandom_range(1, 255)), 8'($urandom_range(0, 255)));
        endcase
        if ($urandom_range(0, 2) == 0)
            send_event(OP_QUERY, tag, 0, 0, 0, 0, 0, 0, 0, 0);
    endtask

    // Arbitrary event with every field random: noise for the sequencer.
    task automatic send_noise();
        send_event(4'($urandom_range(0, 15)), pick_tag(), 1'($urandom_range(0, 1)),
                   2'($urandom_range(0, 3)),
                   ($urandom_range(0, 1) != 0) ? known_gen : rand_word(),
                   1'($urandom_range(0, 1)), rand_word(), 5'($urandom_range(0, 31)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    initial begin
        foreach (recent_tags[i]) recent_tags[i] = 32'h0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty tag, query of nothing, full session at the reset
        // threshold, overflow, replay, stale and unused opcodes.
        send_event(OP_START, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_PUMP, 0, 0, 0, 0, 0, 0, 5'd16, 0, 0);
        send_event(OP_START, 32'hFFFF_FFFF, 1, 2'd3, 0, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < 17; i++)
            send_event(OP_ENQUEUE, 0, 0, 0, 0, 1, (i == 0) ? 32'h0 : ~32'h0 - i, 0, 0, 0);
        send_event(OP_ENQUEUE, 0, 0, 0, 0, 0, 32'h1234, 0, 0, 0);
        send_event(OP_MARK, 0, 0, 0, 32'd1, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_PUMP, 0, 0, 0, 0, 0, 0, 5'd16, 0, 0);
        send_event(OP_DRAIN, 32'hFFFF_FFFF, 0, 0, 32'd1, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_COMPLETE, 0, 0, 0, 32'd1, 0, 0, 0, 8'd255, 8'd255);
        send_event(OP_START, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_QUERY, 32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'h0000_0001, 1, 2'd1, 0, 0, 0, 0, 0, 0);
        send_event(OP_START, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(OP_FAIL, 0, 0, 0, 32'd3, 0, 0, 0, 0, 8'd0);
        send_event(OP_ABORT, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_event(4'd15, 32'hFFFF_FFFF, 1, 2'd3, ~32'h0, 1, ~32'h0, 5'd31, 8'd255, 8'd255);
        send_event(4'd9, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // Random phases across thresholds, the extremes among them.
        base_sent = sent;
        foreach (th_list[k]) begin
            set_threshold(th_list[k]);
            @(posedge i_clk iff pending == 0);
            known_gen = generation_out;
            while (sent - base_sent < (k + 1) * RANDOM_EVENTS / 6) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_noise();
                end else begin
                    run_session();
                end
            end
        end

        // Back pressure: hold off the receiver and keep offering events
        // without gaps so the block stalls its input.
        idle_input();
        long_hold = 1'b1;
        send_event(OP_START, 32'h5A5A_0001, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        for (int i = 0; i < 20; i++)
            send_event(OP_ENQUEUE, 0, 0, 0, 0, 1, rand_word(), 0, 0, 0, 1'b1);

        idle_input();
        @(posedge i_clk iff pending == 0);
        repeat (50) @(posedge i_clk);
        $display("covered %0d events, random and directed, %0d result beats,",
                 sent, beats_seen);
        $display("six preroll thresholds and a long receiver hold-off");
        if (fail_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
